FILE: rtl/assert_macros.svh
// Assertion macros used by the RTL list module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: rtl/oli_pkg.sv
package oli_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;

	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_ERASE  = 2'd1;
	localparam logic [1:0] KIND_READ   = 2'd2;
	localparam logic [1:0] KIND_CLEAR  = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	// Shift command broadcast to every cell of the chain.
	typedef struct packed {
		logic shift_up;
		logic shift_down;
	} cell_cmd_t;

endpackage

FILE: rtl/ordered_list_insert_erase.sv
// The result of an item is strobed on done in the cycle after start.
// Throughput: one item per cycle; busy stays low, since every cell shifts in one step.
// The receiver cannot stall; done lasts exactly one cycle per item.
// Reset (arst_n low, asynchronous) empties the list and clears done; entry data
// is not cleared and is only read below the count.
module ordered_list_insert_erase #(
	parameter int DEPTH      = oli_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = oli_pkg::DATA_WIDTH_DEF,
	localparam int CNT_W     = $clog2(DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            kind,
	input  logic [CNT_W-1:0]      position,
	input  logic [DATA_WIDTH-1:0] value_in,
	output logic                  done,
	output logic [1:0]            status,
	output logic [DATA_WIDTH-1:0] value_out,
	output logic [CNT_W-1:0]      count
);

	`include "assert_macros.svh"

	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

	// The list lives in a row of cells; entries(i) is the word in cell i.
	logic [DATA_WIDTH-1:0] entries [DEPTH];

	logic [CNT_W-1:0]      cnt_q;
	logic                  done_q;
	logic [1:0]            status_q;
	logic [DATA_WIDTH-1:0] value_q;

	oli_pkg::cell_cmd_t    cmd;
	logic                  full;
	logic                  in_range;
	logic                  ins_ok;
	logic                  ers_ok;
	logic [1:0]            status_d;
	logic [DATA_WIDTH-1:0] value_d;
	logic [DATA_WIDTH-1:0] pick;
	logic [CNT_W-1:0]      cnt_d;

	// The list is full when every cell holds an entry. Erase and read need a
	// position inside the held entries; insert may also append at the tail.
	assign full     = cnt_q == DEPTH_C;
	assign in_range = position < cnt_q;
	assign ins_ok   = start && (kind == oli_pkg::KIND_INSERT) && !full && (position <= cnt_q);
	assign ers_ok   = start && (kind == oli_pkg::KIND_ERASE) && in_range;

	assign cmd.shift_up   = ins_ok;
	assign cmd.shift_down = ers_ok;

	// Read port of the chain: each cell either matches the position or
	// contributes zero, so an OR over the row yields the addressed entry.
	always_comb begin
		pick = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (position == CNT_W'(i)) begin
				pick = pick | entries[i];
			end
		end
	end

	// Status and value of the result, and the new count.
	always_comb begin
		status_d = oli_pkg::ST_OK;
		value_d  = '0;
		cnt_d    = cnt_q;
		unique case (kind)
			oli_pkg::KIND_INSERT: begin
				if (full) begin
					status_d = oli_pkg::ST_FULL;
				end else if (position > cnt_q) begin
					status_d = oli_pkg::ST_RANGE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			oli_pkg::KIND_ERASE: begin
				if (!in_range) begin
					status_d = oli_pkg::ST_RANGE;
				end else begin
					value_d = pick;
					cnt_d   = cnt_q - 1'b1;
				end
			end
			oli_pkg::KIND_READ: begin
				if (!in_range) begin
					status_d = oli_pkg::ST_RANGE;
				end else begin
					value_d = pick;
				end
			end
			oli_pkg::KIND_CLEAR: begin
				cnt_d = '0;
			end
			default: begin
				cnt_d = cnt_q;
			end
		endcase
	end

	// The cell chain. Cell 0 has no left neighbor and never shifts up from
	// one; the last cell has no right neighbor and keeps its own word.
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_w;
		logic [DATA_WIDTH-1:0] right_w;

		if (g == 0) begin : g_first
			assign left_w = value_in;
		end else begin : g_mid_l
			assign left_w = entries[g-1];
		end

		if (g == DEPTH - 1) begin : g_last
			assign right_w = entries[g];
		end else begin : g_mid_r
			assign right_w = entries[g+1];
		end

		oli_cell #(
			.DATA_WIDTH(DATA_WIDTH),
			.POS_W     (CNT_W),
			.IDX       (g)
		) u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.position  (position),
			.value_in  (value_in),
			.left_data (left_w),
			.right_data(right_w),
			.data      (entries[g])
		);
	end

	// Control state: the fill count and the result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= start;
			if (start) begin
				cnt_q <= cnt_d;
			end
		end
	end

	// Result payload, loaded with every accepted item.
	always_ff @(posedge clk) begin
		if (start) begin
			status_q <= status_d;
			value_q  <= value_d;
		end
	end

	// Every item is taken as it comes, so the block never refuses one.
	assign busy      = 1'b0;
	assign done      = done_q;
	assign status    = status_q;
	assign value_out = value_q;
	assign count     = cnt_q;

	// Every accepted item gives its result in the next cycle.
	`ASSERT_NEXT(a_done_follows, clk, arst_n, start, done)
	// The count never exceeds the number of cells.
	`ASSERT_SAME(a_count_bound, clk, arst_n, 1'b1, cnt_q <= DEPTH_C)
	// A full report comes only with a full list.
	`ASSERT_SAME(a_full_status, clk, arst_n, done && (status == oli_pkg::ST_FULL),
		count == DEPTH_C)
	// A legal insert grows the list by one entry.
	`ASSERT_NEXT(a_insert_grows, clk, arst_n, ins_ok, cnt_q == $past(cnt_q) + 1'b1)

endmodule

FILE: rtl/oli_cell.sv
module oli_cell #(
	parameter int DATA_WIDTH = oli_pkg::DATA_WIDTH_DEF,
	parameter int POS_W      = 5,
	parameter int IDX        = 0
) (
	input  logic                  clk,
	input  oli_pkg::cell_cmd_t    cmd,
	input  logic [POS_W-1:0]      position,
	input  logic [DATA_WIDTH-1:0] value_in,
	input  logic [DATA_WIDTH-1:0] left_data,
	input  logic [DATA_WIDTH-1:0] right_data,
	output logic [DATA_WIDTH-1:0] data
);

	localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

	logic [DATA_WIDTH-1:0] data_q;
	logic                  above;
	logic                  at;

	assign above = MY_IDX > position;
	assign at    = MY_IDX == position;

	// Insert opens a gap at the position and fills it with value_in; erase closes the gap from the right.
	always_ff @(posedge clk) begin
		if (cmd.shift_up) begin
			if (above) begin
				data_q <= left_data;
			end else if (at) begin
				data_q <= value_in;
			end
		end else if (cmd.shift_down) begin
			if (above || at) begin
				data_q <= right_data;
			end
		end
	end

	assign data = data_q;

endmodule

FILE: test/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH      = oli_pkg::DEPTH_DEF;
	localparam int DATA_WIDTH = oli_pkg::DATA_WIDTH_DEF;
	localparam int CNT_W      = $clog2(DEPTH + 1);

	// Number of random requests in each random phase; four phases give about 950.
	localparam int PHASE_ITEMS = 238;

	// One result of the list: the same three fields that the block strobes out.
	typedef struct packed {
		logic [1:0]            status;
		logic [DATA_WIDTH-1:0] value;
		logic [CNT_W-1:0]      count;
	} list_result_t;

	// One row of the directed table. A row may repeat its request several times,
	// and then the value is varied per repeat. Where known_res is set, the result
	// is typed into the row instead of being taken from the predictor.
	typedef struct packed {
		logic [1:0]            kind;
		logic [CNT_W-1:0]      pos;
		logic [DATA_WIDTH-1:0] value;
		logic [4:0]            reps;
		logic                  known_res;
		list_result_t          res;
	} list_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [1:0]            kind;
	logic [CNT_W-1:0]      position;
	logic [DATA_WIDTH-1:0] value_in;
	logic                  done;
	logic [1:0]            status;
	logic [DATA_WIDTH-1:0] value_out;
	logic [CNT_W-1:0]      count;

	// The testbench's own copy of the list. Only the stimulus process touches it,
	// at the clock edge where a request is taken, so there is no race with the
	// process that checks results.
	logic [DATA_WIDTH-1:0] list_mem [DEPTH];
	int                    list_len;

	// Results that the block still owes, oldest first.
	list_result_t          pending_results [$];

	int n_mismatch;
	int n_items;
	int n_checked;
	int n_full;
	int n_range;
	int n_clear;
	int peak_len;

	// The directed part. It walks an empty list, fills it to the top, and probes
	// both ends and every error: reads and erases on an empty list, inserts past
	// the tail, inserts into a full list (where the full check wins over a bad
	// position), and clears with the other fields set to extremes.
	list_row_t dir_table [25] = '{
		'{oli_pkg::KIND_READ, 5'd0, 32'h0000_0000, 5'd1, 1'b1, '{oli_pkg::ST_RANGE, 32'h0, 5'd0}},
		'{oli_pkg::KIND_ERASE, 5'd0, 32'h0000_0000, 5'd1, 1'b1, '{oli_pkg::ST_RANGE, 32'h0, 5'd0}},
		'{oli_pkg::KIND_INSERT, 5'd1, 32'h0000_0001, 5'd1, 1'b1, '{oli_pkg::ST_RANGE, 32'h0, 5'd0}},
		'{oli_pkg::KIND_CLEAR, 5'd31, 32'hFFFF_FFFF, 5'd1, 1'b1, '{oli_pkg::ST_OK, 32'h0, 5'd0}},
		'{oli_pkg::KIND_INSERT, 5'd0, 32'hFFFF_FFFF, 5'd1, 1'b1, '{oli_pkg::ST_OK, 32'h0, 5'd1}},
		'{oli_pkg::KIND_INSERT, 5'd0, 32'h0000_0000, 5'd1, 1'b1, '{oli_pkg::ST_OK, 32'h0, 5'd2}},
		'{oli_pkg::KIND_INSERT, 5'd2, 32'hA5A5_A5A5, 5'd1, 1'b1, '{oli_pkg::ST_OK, 32'h0, 5'd3}},
		'{oli_pkg::KIND_INSERT, 5'd1, 32'h5A5A_5A5A, 5'd1, 1'b1, '{oli_pkg::ST_OK, 32'h0, 5'd4}},
		'{oli_pkg::KIND_READ, 5'd0, 32'hFFFF_FFFF, 5'd1, 1'b0, '0},
		'{oli_pkg::KIND_READ, 5'd3, 32'h0000_0000, 5'd1, 1'b0, '0},
		'{oli_pkg::KIND_READ, 5'd4, 32'h0000_0000, 5'd1, 1'b1, '{oli_pkg::ST_RANGE, 32'h0, 5'd4}},
		'{oli_pkg::KIND_INSERT, 5'd5, 32'h1234_5678, 5'd1, 1'b1, '{oli_pkg::ST_RANGE, 32'h0, 5'd4}},
		'{oli_pkg::KIND_ERASE, 5'd1, 32'h0000_0000, 5'd1, 1'b0, '0},
		'{oli_pkg::KIND_ERASE, 5'd0, 32'h0000_0000, 5'd1, 1'b0, '0},
		'{oli_pkg::KIND_ERASE, 5'd1, 32'h0000_0000, 5'd1, 1'b0, '0},
		'{oli_pkg::KIND_READ, 5'd31, 32'h0000_0000, 5'd1, 1'b1, '{oli_pkg::ST_RANGE, 32'h0, 5'd1}},
		'{oli_pkg::KIND_INSERT, 5'd1, 32'h8000_0001, 5'd15, 1'b0, '0},
		'{oli_pkg::KIND_INSERT, 5'd17, 32'hDEAD_BEEF, 5'd1, 1'b1, '{oli_pkg::ST_FULL, 32'h0, 5'd16}},
		'{oli_pkg::KIND_INSERT, 5'd0, 32'hFFFF_FFFF, 5'd1, 1'b1, '{oli_pkg::ST_FULL, 32'h0, 5'd16}},
		'{oli_pkg::KIND_READ, 5'd15, 32'h0000_0000, 5'd1, 1'b0, '0},
		'{oli_pkg::KIND_READ, 5'd16, 32'h0000_0000, 5'd1, 1'b1, '{oli_pkg::ST_RANGE, 32'h0, 5'd16}},
		'{oli_pkg::KIND_ERASE, 5'd15, 32'h0000_0000, 5'd1, 1'b0, '0},
		'{oli_pkg::KIND_ERASE, 5'd0, 32'h0000_0000, 5'd1, 1'b0, '0},
		'{oli_pkg::KIND_CLEAR, 5'd0, 32'h0000_0000, 5'd1, 1'b1, '{oli_pkg::ST_OK, 32'h0, 5'd0}},
		'{oli_pkg::KIND_ERASE, 5'd31, 32'hFFFF_FFFF, 5'd1, 1'b1, '{oli_pkg::ST_RANGE, 32'h0, 5'd0}}
	};

	ordered_list_insert_erase u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.kind      (kind),
		.position  (position),
		.value_in  (value_in),
		.done      (done),
		.status    (status),
		.value_out (value_out),
		.count     (count)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Applies one request to the testbench's list and returns what the block
	// should answer. Full is checked before the position on an insert, and any
	// error leaves the list as it was.
	function automatic list_result_t apply_list_request(input logic [1:0] req_kind,
			input logic [CNT_W-1:0] req_pos, input logic [DATA_WIDTH-1:0] req_value);
		list_result_t r;
		int           p;
		r = '0;
		r.status = oli_pkg::ST_OK;
		p = int'(req_pos);
		case (req_kind)
			oli_pkg::KIND_INSERT: begin
				if (list_len >= DEPTH) begin
					r.status = oli_pkg::ST_FULL;
				end else if (p > list_len) begin
					r.status = oli_pkg::ST_RANGE;
				end else begin
					for (int i = list_len; i > p; i--)
						list_mem[i] = list_mem[i-1];
					list_mem[p] = req_value;
					list_len++;
				end
			end
			oli_pkg::KIND_ERASE: begin
				if (p >= list_len) begin
					r.status = oli_pkg::ST_RANGE;
				end else begin
					r.value = list_mem[p];
					for (int i = p; i + 1 < list_len; i++)
						list_mem[i] = list_mem[i+1];
					list_len--;
				end
			end
			oli_pkg::KIND_READ: begin
				if (p >= list_len)
					r.status = oli_pkg::ST_RANGE;
				else
					r.value = list_mem[p];
			end
			default: begin
				list_len = 0;
			end
		endcase
		r.count = list_len[CNT_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(input string field, input logic [DATA_WIDTH-1:0] got,
			input logic [DATA_WIDTH-1:0] want);
		$display("MISMATCH at %0t ns: %s is %0h, predicted %0h", $time, field, got, want);
		n_mismatch++;
	endtask

	// Presents one request and holds it until the block takes it. The request
	// is taken at the first rising edge where busy is low; the prediction is
	// made at that same edge. The caller either presents the next item or
	// lowers start right after, so start never sees two assignments in one step.
	task automatic send_request(input logic [1:0] req_kind, input logic [CNT_W-1:0] req_pos,
			input logic [DATA_WIDTH-1:0] req_value, input logic known_res,
			input list_result_t known);
		list_result_t r;
		start    <= 1'b1;
		kind     <= req_kind;
		position <= req_pos;
		value_in <= req_value;
		do
			@(posedge clk);
		while (busy);
		r = apply_list_request(req_kind, req_pos, req_value);
		if (known_res)
			r = known;
		pending_results.push_back(r);
		n_items++;
		if (r.status == oli_pkg::ST_FULL)
			n_full++;
		if (r.status == oli_pkg::ST_RANGE)
			n_range++;
		if (req_kind == oli_pkg::KIND_CLEAR)
			n_clear++;
		if (list_len > peak_len)
			peak_len = list_len;
	endtask

	// Random requests lean toward inserts so the list often runs full, with
	// enough erases and reads to work both ends and the middle. Most positions
	// are legal for the current length; the rest span the whole 5-bit field.
	task automatic pick_request(output logic [1:0] req_kind, output logic [CNT_W-1:0] req_pos,
			output logic [DATA_WIDTH-1:0] req_value);
		int r;
		r = $urandom_range(99);
		if (r < 50)
			req_kind = oli_pkg::KIND_INSERT;
		else if (r < 72)
			req_kind = oli_pkg::KIND_ERASE;
		else if (r < 93)
			req_kind = oli_pkg::KIND_READ;
		else
			req_kind = oli_pkg::KIND_CLEAR;
		r = $urandom_range(99);
		if (r < 15)
			req_pos = CNT_W'($urandom_range(31));
		else if (req_kind == oli_pkg::KIND_INSERT)
			req_pos = CNT_W'($urandom_range(list_len));
		else if (list_len == 0)
			req_pos = '0;
		else
			req_pos = CNT_W'($urandom_range(list_len - 1));
		r = $urandom_range(9);
		if (r == 0)
			req_value = '0;
		else if (r == 1)
			req_value = '1;
		else
			req_value = $urandom;
	endtask

	// Results come in the cycle after their request and cannot be held off, so
	// every strobe is checked against the oldest prediction as it arrives.
	always @(posedge clk) begin : check_results
		list_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("MISMATCH at %0t ns: result strobed with none outstanding", $time);
				n_mismatch++;
			end else begin
				want = pending_results.pop_front();
				n_checked++;
				if (status !== want.status)
					report_mismatch("status", DATA_WIDTH'(status), DATA_WIDTH'(want.status));
				if (value_out !== want.value)
					report_mismatch("value_out", value_out, want.value);
				if (count !== want.count)
					report_mismatch("count", DATA_WIDTH'(count), DATA_WIDTH'(want.count));
			end
		end
	end

	// Hard stop in case the block hangs.
	initial begin
		#2ms;
		$display("end of test: mismatches");
		$finish;
	end

	initial begin : stimulus
		logic [1:0]            k;
		logic [CNT_W-1:0]      p;
		logic [DATA_WIDTH-1:0] v;
		int                    idle_pct [4];
		int                    drain;
		list_result_t          none;

		none = '0;
		idle_pct = '{0, 52, 0, 12};
		n_mismatch = 0;
		n_items    = 0;
		n_checked  = 0;
		n_full     = 0;
		n_range    = 0;
		n_clear    = 0;
		peak_len   = 0;
		list_len   = 0;

		arst_n   <= 1'b0;
		start    <= 1'b0;
		kind     <= oli_pkg::KIND_READ;
		position <= '0;
		value_in <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows go back to back, with no idle cycles between them.
		foreach (dir_table[row]) begin
			for (int rep = 0; rep < int'(dir_table[row].reps); rep++) begin
				send_request(dir_table[row].kind, dir_table[row].pos,
					dir_table[row].value + DATA_WIDTH'(rep) * 32'h0101_0101,
					dir_table[row].known_res, dir_table[row].res);
			end
		end

		// Random requests in four phases: back to back, a sender idle about
		// half the time, back to back again (the receiver cannot stall), and a
		// sender idle now and then. Idle gaps fall anywhere in the
		// list's history.
		for (int phase = 0; phase < 4; phase++) begin
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(99) < idle_pct[phase]) begin
					start <= 1'b0;
					repeat ($urandom_range(1, 4)) @(posedge clk);
				end
				pick_request(k, p, v);
				send_request(k, p, v, 1'b0, none);
			end
		end
		start <= 1'b0;

		// Wait for the last results; the block answers in the cycle after a
		// request, so a short bound is plenty.
		drain = 0;
		while (pending_results.size() != 0 && drain < 100) begin
			@(posedge clk);
			drain++;
		end
		repeat (4) @(posedge clk);
		if (pending_results.size() != 0) begin
			$display("MISMATCH: %0d results never arrived", pending_results.size());
			n_mismatch++;
		end

		$display("Ran %0d list requests and checked %0d results; the list reached %0d entries.",
			n_items, n_checked, peak_len);
		$display("Saw %0d full-list rejections, %0d bad positions and %0d clears.",
			n_full, n_range, n_clear);
		if (n_mismatch == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl
rtl/oli_pkg.sv
rtl/oli_cell.sv
rtl/ordered_list_insert_erase.sv
test/tb.sv
